// File: design/mmod_pkg.sv
// ----------------------------------------------------------------------------
// mmod_pkg: shared types, constants and decode functions of the memory map
// Region decode of the 16-bit bus, request and status codes, and the
// request bundle that the sequencer hands to the byte store.
// ----------------------------------------------------------------------------
package mmod_pkg;

  // Region sizes
  localparam int ROM_BANK_BYTES  = 16384;
  localparam int VRAM_BYTES      = 8192;
  localparam int WRAM_BANK_BYTES = 4096;
  localparam int SPRITE_BYTES    = 160;
  localparam int IO_BYTES        = 128;
  localparam int HRAM_BYTES      = 127;

  // Index widths
  localparam int ROM_AW  = $clog2(ROM_BANK_BYTES);
  localparam int VRAM_AW = $clog2(VRAM_BYTES);
  localparam int WRAM_AW = $clog2(WRAM_BANK_BYTES);
  localparam int OAM_AW  = $clog2(SPRITE_BYTES);
  localparam int IO_AW   = $clog2(IO_BYTES);
  localparam int HRAM_AW = $clog2(HRAM_BYTES);

  // Region bases
  localparam logic [15:0] BASE_SW   = 16'(ROM_BANK_BYTES);
  localparam logic [15:0] BASE_VRAM = 16'h8000;
  localparam logic [15:0] BASE_WL   = 16'hC000;
  localparam logic [15:0] BASE_WH   = 16'(32'hC000 + WRAM_BANK_BYTES);
  localparam logic [15:0] BASE_OAM  = 16'hFE00;
  localparam logic [15:0] BASE_BAD  = 16'(32'hFE00 + SPRITE_BYTES);
  localparam logic [15:0] BASE_IO   = 16'hFF00;
  localparam logic [15:0] BASE_HRAM = 16'hFF80;
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;
  localparam logic [15:0] DMA_TRIGGER = 16'hFF46;

  // Upper limits of the word windows
  localparam logic [15:0] WORD_RD_ROM_MAX = 16'(2 * ROM_BANK_BYTES - 2);
  localparam logic [15:0] WORD_WL_MAX     = 16'(32'hC000 + WRAM_BANK_BYTES - 2);

  localparam logic [7:0] DMA_CYCLES = 8'(SPRITE_BYTES);
  localparam logic [7:0] DMA_LAST   = 8'(SPRITE_BYTES - 1);

  // Request codes
  localparam logic [1:0] REQ_RD_BYTE = 2'd0;
  localparam logic [1:0] REQ_WR_BYTE = 2'd1;
  localparam logic [1:0] REQ_RD_WORD = 2'd2;
  localparam logic [1:0] REQ_WR_WORD = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FORBIDDEN = 2'd1;
  localparam logic [1:0] ST_FAULT     = 2'd2;

  typedef enum logic [3:0] {
    REG_ROM0,
    REG_ROM1,
    REG_VRAM,
    REG_WRAML,
    REG_WRAMH,
    REG_OAM,
    REG_BAD,
    REG_IO,
    REG_HRAM,
    REG_IE,
    REG_NONE
  } region_e;

  // One cycle of store traffic: a read port and a write port
  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
  } mem_req_t;

  function automatic region_e region_of(input logic [15:0] a);
    region_e r;
    priority if (a < BASE_SW)   r = REG_ROM0;
    else if (a < BASE_VRAM)     r = REG_ROM1;
    else if (a < 16'(32'h8000 + VRAM_BYTES)) r = REG_VRAM;
    else if (a < BASE_WL)       r = REG_NONE;
    else if (a < BASE_WH)       r = REG_WRAML;
    else if (a < 16'(32'hC000 + 2 * WRAM_BANK_BYTES)) r = REG_WRAMH;
    else if (a < BASE_OAM)      r = REG_NONE;
    else if (a < BASE_BAD)      r = REG_OAM;
    else if (a < BASE_IO)       r = REG_BAD;
    else if (a < BASE_HRAM)     r = REG_IO;
    else if (a == ADDR_IE)      r = REG_IE;
    else                        r = REG_HRAM;
    return r;
  endfunction

  function automatic logic readable(input region_e r);
    return (r != REG_NONE) && (r != REG_BAD);
  endfunction

  function automatic logic word_read_ok(input logic [15:0] a);
    return (a <= WORD_RD_ROM_MAX) || ((a >= BASE_WL) && (a <= WORD_WL_MAX));
  endfunction

  function automatic logic word_write_ok(input logic [15:0] a);
    return (a >= BASE_WL) && (a <= WORD_WL_MAX);
  endfunction

  // A DMA source page is fully mapped unless it lies in a hole of the map;
  // the top page reaches into I/O and high RAM only, both mapped throughout.
  function automatic logic page_ok(input logic [7:0] p);
    return !((p >= 8'hA0) && (p <= 8'hBF)) && !((p >= 8'hE0) && (p <= 8'hFD));
  endfunction

endpackage

// File: design/memory_map_with_oam_dma_unit.sv
// Faults, ignored writes and byte writes load the result at the accepting edge; a byte
// read loads it in S_RD, a word write in S_WW_HI, a word read in S_RW_HI after S_RW_LO.
// Sprite DMA: each byte is read through the single store read port, then written.
// One request at a time; a new beat is taken once the result register is free.
// Reset clears the sequencer, the result valid and the interrupt enable byte;
// all RAM contents are undefined until written.
// ----------------------------------------------------------------------------
// memory_map_with_oam_dma_unit: 16-bit bus decoder with sprite DMA
// Sequencer over a byte store: byte and word accesses, forbidden-area and
// unmapped checks, and the 160-byte sprite copy triggered at 0xFF46.
// ----------------------------------------------------------------------------
module memory_map_with_oam_dma_unit
  import mmod_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [7:0]  dma_cycles_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_RW_LO  = 3'd2;
  localparam logic [2:0] S_RW_HI  = 3'd3;
  localparam logic [2:0] S_WW_HI  = 3'd4;
  localparam logic [2:0] S_DMA_RD = 3'd5;
  localparam logic [2:0] S_DMA_WR = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [15:0] addr_q;
  logic [15:0] data_q;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        out_valid_q;
  logic [15:0] read_data_q;
  logic [1:0]  status_q;
  logic [7:0]  dma_cycles_q;

  logic        in_accept;
  logic        res_load;
  logic [15:0] res_rd;
  logic [1:0]  res_st;
  logic [7:0]  res_cyc;
  mem_req_t    mem_req;
  logic [7:0]  mem_rd;
  region_e     in_reg;

  mmod_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_reg     = region_of(address_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    mem_req = '0;
    res_load = 1'b0;
    res_rd  = 16'h0000;
    res_st  = ST_OK;
    res_cyc = 8'h00;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (req_type_i)
            REQ_RD_BYTE: begin
              if (readable(in_reg)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = address_i;
                state_d = S_RD;
              end else begin
                res_load = 1'b1;
                res_st   = ST_FAULT;
              end
            end
            REQ_WR_BYTE: begin
              res_load = 1'b1;
              priority if (address_i == DMA_TRIGGER) begin
                if (page_ok(write_data_i[7:0])) begin
                  res_load = 1'b0;
                  cnt_d    = 8'h00;
                  state_d  = S_DMA_RD;
                end else begin
                  res_st = ST_FAULT;
                end
              end else if (in_reg == REG_BAD) begin
                res_st = ST_FORBIDDEN;
              end else if (in_reg == REG_NONE) begin
                res_st = ST_FAULT;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = address_i;
                mem_req.wr_data = write_data_i[7:0];
              end
            end
            REQ_RD_WORD: begin
              if (word_read_ok(address_i)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = address_i;
                state_d = S_RW_LO;
              end else begin
                res_load = 1'b1;
                res_st   = ST_FAULT;
              end
            end
            REQ_WR_WORD: begin
              if (word_write_ok(address_i)) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = address_i;
                mem_req.wr_data = write_data_i[7:0];
                state_d = S_WW_HI;
              end else begin
                res_load = 1'b1;
                res_st   = ST_FAULT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_load = 1'b1;
        res_rd   = {8'h00, mem_rd};
        state_d  = S_IDLE;
      end
      S_RW_LO: begin
        // Low byte back; fetch the next byte, which may sit in the next bank
        lo_d = mem_rd;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = addr_q + 16'd1;
        state_d = S_RW_HI;
      end
      S_RW_HI: begin
        res_load = 1'b1;
        res_rd   = {mem_rd, lo_q};
        state_d  = S_IDLE;
      end
      S_WW_HI: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr_q + 16'd1;
        mem_req.wr_data = data_q[15:8];
        res_load = 1'b1;
        state_d  = S_IDLE;
      end
      S_DMA_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = {data_q[7:0], cnt_q};
        state_d = S_DMA_WR;
      end
      S_DMA_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = BASE_OAM | {8'h00, cnt_q};
        mem_req.wr_data = mem_rd;
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == DMA_LAST) begin
          res_load = 1'b1;
          res_cyc  = DMA_CYCLES;
          state_d  = S_IDLE;
        end else begin
          state_d = S_DMA_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    cnt_q <= cnt_d;
    if (in_accept) begin
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (res_load) begin
      read_data_q  <= res_rd;
      status_q     <= res_st;
      dma_cycles_q <= res_cyc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign status_o     = status_q;
  assign dma_cycles_o = dma_cycles_q;

  // Checks
  a_no_trigger_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (mem_req.wr_addr != DMA_TRIGGER))
    else $error("store write at DMA trigger address");

  a_dma_to_oam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DMA_WR) |-> (region_of(mem_req.wr_addr) == REG_OAM))
    else $error("DMA write outside sprite RAM");

  a_dma_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DMA_RD) || (state_q == S_DMA_WR)) |-> (cnt_q <= DMA_LAST))
    else $error("DMA count past sprite RAM");

  a_dma_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (dma_cycles_q != 8'h00)) |->
      ((status_q == ST_OK) && (read_data_q == 16'h0000)))
    else $error("DMA cycles reported with fault or read data");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before delivery");

endmodule

// File: design/mmod_store.sv
// ----------------------------------------------------------------------------
// mmod_store: byte-wide storage behind the bus map
// One byte read and one byte write a cycle; read data is registered, so it
// appears in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module mmod_store
  import mmod_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] rom0_mem [ROM_BANK_BYTES];
  logic [7:0] rom1_mem [ROM_BANK_BYTES];
  logic [7:0] vram_mem [VRAM_BYTES];
  logic [7:0] wl_mem   [WRAM_BANK_BYTES];
  logic [7:0] wh_mem   [WRAM_BANK_BYTES];
  logic [7:0] oam_mem  [SPRITE_BYTES];
  logic [7:0] io_mem   [IO_BYTES];
  logic [7:0] hram_mem [HRAM_BYTES];

  logic [7:0] rom0_rd_q, rom1_rd_q, vram_rd_q, wl_rd_q, wh_rd_q;
  logic [7:0] oam_rd_q, io_rd_q, hram_rd_q, ie_rd_q;
  logic [7:0] ie_q;
  region_e    rd_reg, wr_reg, rd_reg_q;
  logic [15:0] ra, wa;

  assign ra     = req_i.rd_addr;
  assign wa     = req_i.wr_addr;
  assign rd_reg = region_of(ra);
  assign wr_reg = region_of(wa);

  // Writes
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      unique case (wr_reg)
        REG_ROM0:  rom0_mem[wa[ROM_AW-1:0]]  <= req_i.wr_data;
        REG_ROM1:  rom1_mem[wa[ROM_AW-1:0]]  <= req_i.wr_data;
        REG_VRAM:  vram_mem[wa[VRAM_AW-1:0]] <= req_i.wr_data;
        REG_WRAML: wl_mem[wa[WRAM_AW-1:0]]   <= req_i.wr_data;
        REG_WRAMH: wh_mem[wa[WRAM_AW-1:0]]   <= req_i.wr_data;
        REG_OAM:   oam_mem[wa[OAM_AW-1:0]]   <= req_i.wr_data;
        REG_IO:    io_mem[wa[IO_AW-1:0]]     <= req_i.wr_data;
        REG_HRAM:  hram_mem[wa[HRAM_AW-1:0]] <= req_i.wr_data;
        default: ;
      endcase
    end
  end

  // Interrupt enable byte resets to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ie_q <= 8'h00;
    end else if (req_i.wr_en && (wr_reg == REG_IE)) begin
      ie_q <= req_i.wr_data;
    end
  end

  // Registered reads, one memory per region
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_reg_q <= rd_reg;
      unique case (rd_reg)
        REG_ROM0:  rom0_rd_q <= rom0_mem[ra[ROM_AW-1:0]];
        REG_ROM1:  rom1_rd_q <= rom1_mem[ra[ROM_AW-1:0]];
        REG_VRAM:  vram_rd_q <= vram_mem[ra[VRAM_AW-1:0]];
        REG_WRAML: wl_rd_q   <= wl_mem[ra[WRAM_AW-1:0]];
        REG_WRAMH: wh_rd_q   <= wh_mem[ra[WRAM_AW-1:0]];
        REG_OAM:   oam_rd_q  <= oam_mem[ra[OAM_AW-1:0]];
        REG_IO:    io_rd_q   <= io_mem[ra[IO_AW-1:0]];
        REG_HRAM:  hram_rd_q <= hram_mem[ra[HRAM_AW-1:0]];
        REG_IE:    ie_rd_q   <= ie_q;
        default: ;
      endcase
    end
  end

  // Select the region that was read
  always_comb begin
    unique case (rd_reg_q)
      REG_ROM0:  rd_data_o = rom0_rd_q;
      REG_ROM1:  rd_data_o = rom1_rd_q;
      REG_VRAM:  rd_data_o = vram_rd_q;
      REG_WRAML: rd_data_o = wl_rd_q;
      REG_WRAMH: rd_data_o = wh_rd_q;
      REG_OAM:   rd_data_o = oam_rd_q;
      REG_IO:    rd_data_o = io_rd_q;
      REG_HRAM:  rd_data_o = hram_rd_q;
      REG_IE:    rd_data_o = ie_rd_q;
      default:   rd_data_o = 8'h00;
    endcase
  end

endmodule

// File: bench/memory_map_with_oam_dma_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_with_oam_dma_unit_test: self-checking bench for the bus decoder
// Drives byte and word requests over the whole 16-bit map and sprite DMA
// copies, predicts every response from a flat image of the map and compares
// each response beat in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module memory_map_with_oam_dma_unit_test
  import mmod_pkg::*;
();

  typedef struct packed {
    logic [15:0] rd;
    logic [1:0]  st;
    logic [7:0]  cyc;
  } bus_resp_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i   = REQ_RD_BYTE;
  logic [15:0] address_i    = 16'h0000;
  logic [15:0] write_data_i = 16'h0000;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [15:0] read_data_o;
  logic [1:0]  status_o;
  logic [7:0]  dma_cycles_o;

  // Flat image of the map: every region maps one bus address to one byte
  logic [7:0]  bus_img   [0:65535];
  bit          img_valid [0:65535];
  logic [15:0] written_q [$];
  logic [7:0]  ready_pages [$];
  bus_resp_t   pending_responses [$];

  bit fe_listed      = 1'b0;
  bit no_gaps        = 1'b0;
  int beats_sent     = 0;
  int mismatch_count = 0;
  int stall_left     = 0;

  memory_map_with_oam_dma_unit i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Map helpers
  // --------------------------------------------------------------------------
  function automatic bit is_mapped(input logic [15:0] a);
    return (a < BASE_VRAM + VRAM_BYTES) ||
           (a >= BASE_WL && a < BASE_WL + 2 * WRAM_BANK_BYTES) ||
           (a >= BASE_OAM && a < BASE_BAD) || (a >= BASE_IO);
  endfunction

  function automatic bit word_wr_window(input logic [15:0] a);
    return (a >= BASE_WL) && (a <= BASE_WL + WRAM_BANK_BYTES - 2);
  endfunction

  function automatic bit word_rd_window(input logic [15:0] a);
    return (a <= 2 * ROM_BANK_BYTES - 2) || word_wr_window(a);
  endfunction

  function automatic void store_byte(input logic [15:0] a, input logic [7:0] v);
    if (!img_valid[a]) begin
      img_valid[a] = 1'b1;
      written_q.push_back(a);
    end
    bus_img[a] = v;
  endfunction

  // True when a DMA from this page reads no byte that was never written
  function automatic bit page_safe(input logic [7:0] p);
    logic [15:0] src;
    bit all_set;
    all_set = 1'b1;
    for (int i = 0; i < SPRITE_BYTES; i++) begin
      src = {p, 8'h00} + 16'(i);
      if (!is_mapped(src)) return 1'b1;
      if (!img_valid[src]) all_set = 1'b0;
    end
    return all_set;
  endfunction

  // Sprite copy: all sources checked first, then copied in ascending order
  function automatic bit copy_sprite_page(input logic [7:0] p);
    logic [15:0] src;
    for (int i = 0; i < SPRITE_BYTES; i++) begin
      src = {p, 8'h00} + 16'(i);
      if (!is_mapped(src)) return 1'b0;
    end
    for (int i = 0; i < SPRITE_BYTES; i++) begin
      src = {p, 8'h00} + 16'(i);
      store_byte(BASE_OAM + 16'(i), bus_img[src]);
    end
    return 1'b1;
  endfunction

  // Expected response of one request; updates the image as the block would
  function automatic bus_resp_t bus_response(input logic [1:0] req, input logic [15:0] a,
                                             input logic [15:0] d);
    bus_resp_t r;
    r = '0;
    case (req)
      REQ_RD_BYTE: begin
        if (is_mapped(a)) r.rd = {8'h00, bus_img[a]};
        else r.st = ST_FAULT;
      end
      REQ_WR_BYTE: begin
        if (a >= BASE_BAD && a < BASE_IO) r.st = ST_FORBIDDEN;
        else if (a == DMA_TRIGGER) begin
          if (copy_sprite_page(d[7:0])) r.cyc = DMA_CYCLES;
          else r.st = ST_FAULT;
        end else if (is_mapped(a)) store_byte(a, d[7:0]);
        else r.st = ST_FAULT;
      end
      REQ_RD_WORD: begin
        if (word_rd_window(a)) r.rd = {bus_img[a + 16'd1], bus_img[a]};
        else r.st = ST_FAULT;
      end
      default: begin
        if (word_wr_window(a)) begin
          store_byte(a, d[7:0]);
          store_byte(a + 16'd1, d[15:8]);
        end else r.st = ST_FAULT;
      end
    endcase
    return r;
  endfunction

  // A request must never read a mapped byte that was never written
  function automatic bit harmless(input logic [1:0] req, input logic [15:0] a,
                                  input logic [15:0] d);
    case (req)
      REQ_RD_BYTE: return !is_mapped(a) || img_valid[a];
      REQ_WR_BYTE: return (a != DMA_TRIGGER) || page_safe(d[7:0]);
      REQ_RD_WORD: return !word_rd_window(a) || (img_valid[a] && img_valid[a + 16'd1]);
      default:     return 1'b1;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] dead_page();
    if ($urandom_range(0, 1) == 0) return 8'hA0 + 8'($urandom_range(0, 31));
    return 8'hE0 + 8'($urandom_range(0, 29));
  endfunction

  // Fully mapped source pages; the top page is left out as it holds 0xFF46
  function automatic logic [7:0] live_page();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 8'h7F));
      1:       return 8'h80 + 8'($urandom_range(0, 31));
      2:       return 8'hC0 + 8'($urandom_range(0, 31));
      default: return 8'hFE;
    endcase
  endfunction

  function automatic logic [15:0] boundary_addr(input int k);
    case (k)
      0: return 16'h0000;   1: return 16'h3FFF;   2: return 16'h4000;
      3: return 16'h7FFE;   4: return 16'h7FFF;   5: return 16'h8000;
      6: return 16'h9FFF;   7: return 16'hA000;   8: return 16'hBFFF;
      9: return 16'hC000;  10: return 16'hCFFE;  11: return 16'hCFFF;
      12: return 16'hD000; 13: return 16'hDFFF;  14: return 16'hE000;
      15: return 16'hFDFF; 16: return 16'hFE00;  17: return 16'hFE9F;
      18: return 16'hFEA0; 19: return 16'hFEFF;  20: return 16'hFF00;
      21: return 16'hFF46; 22: return 16'hFF7F;  23: return 16'hFF80;
      24: return 16'hFFFE; default: return 16'hFFFF;
    endcase
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch %0d: %s", mismatch_count, msg);
  endfunction

  // One request beat: optional idle gap, hold valid until accepted, predict
  task automatic send_beat(input logic [1:0] req, input logic [15:0] addr,
                           input logic [15:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    pending_responses.push_back(bus_response(req, addr, data));
    beats_sent++;
  endtask

  // Stop sending and wait for every outstanding response
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  // Write every missing byte of a source page; work RAM low pages by words
  task automatic fill_page(input logic [7:0] p);
    logic [15:0] base;
    base = {p, 8'h00};
    if (p >= 8'hC0 && p <= 8'hCF) begin
      for (int i = 0; i < SPRITE_BYTES; i += 2)
        if (!img_valid[base + 16'(i)] || !img_valid[base + 16'(i + 1)])
          send_beat(REQ_WR_WORD, base + 16'(i), 16'($urandom));
    end else begin
      for (int i = 0; i < SPRITE_BYTES; i++)
        if (!img_valid[base + 16'(i)])
          send_beat(REQ_WR_BYTE, base + 16'(i), 16'($urandom));
    end
  endtask

  // One sprite DMA: faulting page, known page, or a freshly filled page
  task automatic sprite_dma_round(inout int fills_left);
    logic [7:0] p;
    if ($urandom_range(0, 4) == 0) p = dead_page();
    else if (ready_pages.size() > 0 && (fills_left == 0 || $urandom_range(0, 3) != 0))
      p = ready_pages[$urandom_range(0, ready_pages.size() - 1)];
    else begin
      p = live_page();
      fill_page(p);
      fills_left--;
      ready_pages.push_back(p);
    end
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, {8'($urandom), p});
    if (!fe_listed && page_safe(8'hFE)) begin
      ready_pages.push_back(8'hFE);
      fe_listed = 1'b1;
    end
  endtask

  // One random request, turned into a write where it would read unset bytes
  task automatic random_access();
    logic [1:0]  req;
    logic [15:0] a;
    logic [15:0] d;
    int          k;
    req = 2'($urandom_range(0, 3));
    d   = 16'($urandom);
    k   = $urandom_range(0, 9);
    case (k)
      0, 1: a = 16'($urandom);
      2:    a = boundary_addr($urandom_range(0, 25));
      3, 4: a = BASE_WL + 16'($urandom_range(0, WRAM_BANK_BYTES - 1));
      5, 6: begin
        req = ($urandom_range(0, 1) == 0) ? REQ_RD_BYTE : REQ_RD_WORD;
        a = written_q[$urandom_range(0, written_q.size() - 1)];
        if (req == REQ_RD_WORD && $urandom_range(0, 1) == 0) a = a - 16'd1;
      end
      7:    a = 16'($urandom_range(0, 16'h7FFF));
      8:    a = BASE_IO + 16'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 2))
          0:       a = BASE_VRAM + 16'($urandom_range(0, VRAM_BYTES - 1));
          1:       a = BASE_WH + 16'($urandom_range(0, WRAM_BANK_BYTES - 1));
          default: a = BASE_OAM + 16'($urandom_range(0, 255));
        endcase
      end
    endcase
    if (!harmless(req, a, d)) begin
      if (req == REQ_RD_WORD && img_valid[a]) a = a + 16'd1;
      req = REQ_WR_BYTE;
      if (!harmless(req, a, d)) d[7:0] = dead_page();
    end
    send_beat(req, a, d);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Region edges, word windows, the straddling ROM read, faults and DMA faults
  task automatic test_directed_cases();
    send_beat(REQ_WR_BYTE, 16'h0000, 16'hFFAA);
    send_beat(REQ_RD_BYTE, 16'h0000, 16'h0000);
    send_beat(REQ_WR_BYTE, 16'h3FFF, 16'h0011);
    send_beat(REQ_WR_BYTE, 16'h4000, 16'h0022);
    send_beat(REQ_RD_WORD, 16'h3FFF, 16'h0000);
    send_beat(REQ_WR_WORD, 16'hC000, 16'hFFFF);
    send_beat(REQ_RD_WORD, 16'hC000, 16'h0000);
    send_beat(REQ_WR_WORD, 16'hCFFE, 16'h0000);
    send_beat(REQ_RD_WORD, 16'hCFFE, 16'hFFFF);
    send_beat(REQ_RD_WORD, 16'hCFFF, 16'h0000);
    send_beat(REQ_WR_WORD, 16'hCFFF, 16'h1234);
    send_beat(REQ_WR_WORD, 16'h0000, 16'h5678);
    send_beat(REQ_RD_WORD, 16'h8000, 16'h0000);
    send_beat(REQ_RD_WORD, 16'hFFFF, 16'h0000);
    send_beat(REQ_RD_BYTE, 16'hA000, 16'h0000);
    send_beat(REQ_WR_BYTE, 16'hBFFF, 16'h00FF);
    send_beat(REQ_RD_BYTE, 16'hFDFF, 16'h0000);
    send_beat(REQ_WR_BYTE, 16'hFEA0, 16'h0055);
    send_beat(REQ_WR_BYTE, 16'hFEFF, 16'h00AA);
    send_beat(REQ_RD_BYTE, 16'hFEFF, 16'h0000);
    send_beat(REQ_RD_BYTE, ADDR_IE, 16'h0000);
    send_beat(REQ_WR_BYTE, ADDR_IE, 16'h005A);
    send_beat(REQ_RD_BYTE, ADDR_IE, 16'h0000);
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, 16'h00A0);
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, 16'h00FD);
  endtask

  // Copy from work RAM, faulting copy leaves sprite RAM alone, self copy
  task automatic test_sprite_dma();
    fill_page(8'hC2);
    ready_pages.push_back(8'hC2);
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, 16'hFFC2);
    send_beat(REQ_RD_BYTE, BASE_OAM, 16'h0000);
    send_beat(REQ_RD_BYTE, BASE_BAD - 16'd1, 16'h0000);
    send_beat(REQ_WR_BYTE, 16'hFE10, 16'($urandom));
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, {8'h00, dead_page()});
    send_beat(REQ_RD_BYTE, 16'hFE10, 16'h0000);
    send_beat(REQ_WR_BYTE, DMA_TRIGGER, 16'h00FE);
    send_beat(REQ_RD_BYTE, 16'hFE10, 16'h0000);
    ready_pages.push_back(8'hFE);
    fe_listed = 1'b1;
  endtask

  // Mixed traffic with DMA rounds, quiet stretches and one full drain
  task automatic test_random_traffic(input int count);
    int stop;
    int fills_left;
    bit drained;
    stop       = beats_sent + count;
    fills_left = 4;
    drained    = 1'b0;
    while (beats_sent < stop) begin
      no_gaps = ((beats_sent / 150) % 5 == 4);
      if (!drained && beats_sent >= stop - count / 2) begin
        drained = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 3) sprite_dma_round(fills_left);
      else random_access();
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_out_ready
    int hold;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      hold = pick_gap();
      if (hold > 0) begin
        stall_left = hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    bus_resp_t got;
    bus_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {read_data_o, status_o, dma_cycles_o};
      if (pending_responses.size() == 0) begin
        log_mismatch($sformatf("unexpected beat rd=%h st=%0d cyc=%0d",
                               got.rd, got.st, got.cyc));
      end else begin
        want = pending_responses.pop_front();
        if (got.rd !== want.rd || got.st !== want.st || got.cyc !== want.cyc)
          log_mismatch($sformatf("rd exp %h got %h, st exp %0d got %0d, cyc exp %0d got %0d",
                                 want.rd, got.rd, want.st, got.st, want.cyc, got.cyc));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    // interrupt enable is the only byte with a defined reset value
    bus_img[ADDR_IE]   = 8'h00;
    img_valid[ADDR_IE] = 1'b1;
    written_q.push_back(ADDR_IE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_sprite_dma();
    test_random_traffic(1800);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Hang guard
  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
